>>> rtl/lagrange_interpolation_evaluator_core_assert.svh
// assertion macros used by the checker file
`ifndef LAGRANGE_INTERPOLATION_EVALUATOR_CORE_ASSERT_SVH
`define LAGRANGE_INTERPOLATION_EVALUATOR_CORE_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define LIE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must never be seen at a clock edge out of reset
`define LIE_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> rtl/lie_pkg.sv
`default_nettype none

package lie_pkg;

  // widths of the intermediate q32.16 format and of a magnitude before clamping
  localparam int WideW = 48;
  localparam int MagW  = 80;

  localparam int MaxNodesDef = 16;

  localparam logic [4:0] NodeCountRst = 5'd2;

  // operation codes
  localparam logic OpWrite = 1'b0;
  localparam logic OpEval  = 1'b1;

  // status codes
  localparam logic [1:0] StatusOk  = 2'd0;
  localparam logic [1:0] StatusDup = 2'd1;
  localparam logic [1:0] StatusSat = 2'd2;

  localparam logic signed [WideW-1:0] QOne    = 48'sd65536;
  localparam logic signed [WideW-1:0] WideMax = {1'b0, {(WideW-1){1'b1}}};
  localparam logic signed [WideW-1:0] WideMin = {1'b1, {(WideW-1){1'b0}}};

  localparam logic [MagW-1:0] NegLimit = {{(MagW-WideW){1'b0}}, 1'b1, {(WideW-1){1'b0}}};
  localparam logic [MagW-1:0] PosLimit = NegLimit - MagW'(1);

  typedef struct packed {
    logic                    sat;
    logic signed [WideW-1:0] res;
  } wide_val_t;

  // result of a shared arithmetic unit
  typedef struct packed {
    logic                    done;
    logic                    sat;
    logic signed [WideW-1:0] res;
  } wide_res_t;

  // apply sign to a magnitude and clamp to the wide range
  function automatic wide_val_t sat_wide(input logic neg, input logic [MagW-1:0] mag);
    wide_val_t r;
    r.sat = 1'b0;
    r.res = '0;
    if (neg) begin
      if (mag > NegLimit) begin
        r.sat = 1'b1;
        r.res = WideMin;
      end else begin
        r.res = $signed(WideW'(0) - mag[WideW-1:0]);
      end
    end else begin
      if (mag > PosLimit) begin
        r.sat = 1'b1;
        r.res = WideMax;
      end else begin
        r.res = $signed(mag[WideW-1:0]);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/lie_ram.sv
`default_nettype none

module lie_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/lie_div.sv
`default_nettype none

module lie_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [32:0] num_i,
  input  wire logic signed [32:0] den_i,
  output      lie_pkg::wide_res_t res_o
);

  import lie_pkg::*;

  localparam int DvdW = 48;

  logic [DvdW-1:0] dvd_q, dvd_d;
  logic [31:0]     dvs_q, dvs_d;
  logic [31:0]     rem_q, rem_d;
  logic            neg_q, neg_d;
  logic [5:0]      cnt_q, cnt_d;
  logic            done_q, done_d;

  logic [32:0] num_mag, den_mag, trial;
  wide_val_t   fin;

  assign num_mag = num_i[32] ? 33'(-num_i) : 33'(num_i);
  assign den_mag = den_i[32] ? 33'(-den_i) : 33'(den_i);
  assign trial   = {rem_q, dvd_q[DvdW-1]};

  // restoring division, one quotient bit a cycle
  always_comb begin
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d = {num_mag[31:0], 16'b0};
      dvs_d = den_mag[31:0];
      rem_d = '0;
      neg_d = num_i[32] ^ den_i[32];
      cnt_d = 6'(DvdW);
    end else if (cnt_q != '0) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = 32'(trial - {1'b0, dvs_q});
        dvd_d = {dvd_q[DvdW-2:0], 1'b1};
      end else begin
        rem_d = trial[31:0];
        dvd_d = {dvd_q[DvdW-2:0], 1'b0};
      end
      cnt_d  = cnt_q - 6'd1;
      done_d = (cnt_q == 6'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
  end

  // signed, clamped quotient
  assign fin       = sat_wide(neg_q, MagW'(dvd_q));
  assign res_o.done = done_q;
  assign res_o.sat  = fin.sat;
  assign res_o.res  = fin.res;

endmodule

`default_nettype wire

>>> rtl/lie_mul.sv
`default_nettype none

module lie_mul (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic signed [lie_pkg::WideW-1:0] a_i,
  input  wire logic signed [lie_pkg::WideW-1:0] b_i,
  output      lie_pkg::wide_res_t               res_o
);

  import lie_pkg::*;

  localparam int DigW   = 16;
  localparam int Digits = WideW / DigW;
  localparam int AccW   = 2 * WideW;

  logic [WideW-1:0] ma_q, ma_d, mb_q, mb_d;
  logic [AccW-1:0]  acc_q, acc_d;
  logic             neg_q, neg_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             done_q, done_d;

  logic [WideW-1:0]      a_mag, b_mag;
  logic [DigW+WideW-1:0] pp;
  wide_val_t             fin;

  assign a_mag = a_i[WideW-1] ? WideW'(-a_i) : WideW'(a_i);
  assign b_mag = b_i[WideW-1] ? WideW'(-b_i) : WideW'(b_i);
  assign pp    = ma_q[WideW-1 -: DigW] * mb_q;

  // one 16-bit digit of the first operand a cycle, most significant first
  always_comb begin
    ma_d   = ma_q;
    mb_d   = mb_q;
    acc_d  = acc_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      ma_d  = a_mag;
      mb_d  = b_mag;
      acc_d = '0;
      neg_d = a_i[WideW-1] ^ b_i[WideW-1];
      cnt_d = 2'(Digits);
    end else if (cnt_q != '0) begin
      acc_d  = {acc_q[AccW-DigW-1:0], {DigW{1'b0}}} + AccW'(pp);
      ma_d   = {ma_q[WideW-DigW-1:0], {DigW{1'b0}}};
      cnt_d  = cnt_q - 2'd1;
      done_d = (cnt_q == 2'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ma_q  <= ma_d;
    mb_q  <= mb_d;
    acc_q <= acc_d;
    neg_q <= neg_d;
  end

  // drop 16 fraction bits, then sign and clamp
  assign fin        = sat_wide(neg_q, acc_q[AccW-1:DigW]);
  assign res_o.done = done_q;
  assign res_o.sat  = fin.sat;
  assign res_o.res  = fin.res;

endmodule

`default_nettype wire

>>> rtl/lagrange_interpolation_evaluator_core.sv
// Lagrange interpolation evaluator in signed Q16.16. A write item (operation 0) stores one
// node in a node memory and gives no result. An evaluate item (operation 1) returns the
// interpolating polynomial at query_point over the first node_count nodes (at most
// MAX_NODES), with status 0 ok, 1 duplicate abscissae (value 0) or 2 saturated. One item is
// worked on at a time. An evaluate keeps the input stalled, and its result is offered as the
// input is released. Each basis factor takes a node fetch, a pass through the shared radix-2
// divider (48 steps) and one through the multiplier (three 16-bit digit steps). Each node adds
// its own fetch, the end of its inner loop and a weighting multiply. An evaluate ends early
// when it meets two equal abscissae. A waiting result does not block the input, but a finished
// evaluate keeps the input stalled until its result can be offered. node_count is written
// through the configuration channel, which is always ready; write it only while the block is
// idle. Nodes must be written before an evaluate uses them; the memory needs no clearing.
`default_nettype none

module lagrange_interpolation_evaluator_core #(
  parameter int MAX_NODES = lie_pkg::MaxNodesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic        operation_i,
  input  wire logic [3:0]  node_index_i,
  input  wire logic [31:0] node_abscissa_i,
  input  wire logic [31:0] node_ordinate_i,
  input  wire logic [31:0] query_point_i,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic [31:0] value_o,
  output      logic [1:0]  status_o,
  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic [4:0]  cfg_data_i
);

  import lie_pkg::*;

  localparam int AW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_RDI  = 9'b000000010,
    ST_LDI  = 9'b000000100,
    ST_RDJ  = 9'b000001000,
    ST_LDJ  = 9'b000010000,
    ST_DIV  = 9'b000100000,
    ST_MUL  = 9'b001000000,
    ST_TERM = 9'b010000000,
    ST_DONE = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [4:0]    node_count_q;
  logic [CW-1:0] n_q, n_d, i_q, i_d, j_q, j_d;
  logic [31:0]   x_q, x_d, xi_q, xi_d, yi_q, yi_d;
  logic signed [WideW-1:0] basis_q, basis_d, sum_q, sum_d;
  logic          sat_q, sat_d, dup_q, dup_d, term_q, term_d;
  logic          out_valid_q, out_valid_d;
  logic [31:0]   value_q, value_d;
  logic [1:0]    status_q, status_d;

  logic          in_acc, ram_we, div_start, mul_start, out_load;
  logic [AW-1:0] ram_raddr;
  logic [63:0]   ram_rdata;
  logic [31:0]   rd_x, rd_y;
  logic signed [32:0] div_num, div_den;
  logic signed [WideW-1:0] mul_a, mul_b;
  logic [WideW:0] sum_ext;
  wide_res_t      div_res, mul_res;

  assign in_acc      = in_valid_i & ~in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign ram_we      = in_acc & (operation_i == OpWrite) & (int'(node_index_i) < MAX_NODES);
  assign ram_raddr   = (state_q == ST_RDI) ? i_q[AW-1:0] : j_q[AW-1:0];
  assign rd_x        = ram_rdata[63:32];
  assign rd_y        = ram_rdata[31:0];
  assign div_num     = $signed({x_q[31], x_q}) - $signed({rd_x[31], rd_x});
  assign div_den     = $signed({xi_q[31], xi_q}) - $signed({rd_x[31], rd_x});
  assign mul_a       = (state_q == ST_TERM) ? WideW'($signed(yi_q)) : basis_q;
  assign mul_b       = (state_q == ST_TERM) ? basis_q : div_res.res;
  assign sum_ext     = {sum_q[WideW-1], sum_q} + {mul_res.res[WideW-1], mul_res.res};

  // node memory: abscissa in the upper half, ordinate in the lower
  lie_ram #(
    .WIDTH(64),
    .DEPTH(MAX_NODES)
  ) u_node_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(AW'(node_index_i)),
    .wdata_i({node_abscissa_i, node_ordinate_i}),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  lie_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .res_o  (div_res)
  );

  lie_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .res_o  (mul_res)
  );

  // evaluation sequencer: outer loop over i, inner loop over j
  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    i_d         = i_q;
    j_d         = j_q;
    x_d         = x_q;
    xi_d        = xi_q;
    yi_d        = yi_q;
    basis_d     = basis_q;
    sum_d       = sum_q;
    sat_d       = sat_q;
    dup_d       = dup_q;
    term_d      = term_q;
    div_start   = 1'b0;
    mul_start   = 1'b0;
    out_load    = 1'b0;
    out_valid_d = out_valid_q & out_stall_i;
    value_d     = value_q;
    status_d    = status_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && operation_i == OpEval) begin
          x_d   = query_point_i;
          sum_d = '0;
          sat_d = 1'b0;
          dup_d = 1'b0;
          i_d   = '0;
          if (int'(node_count_q) > MAX_NODES) begin
            n_d = CW'(MAX_NODES);
          end else begin
            n_d = CW'(node_count_q);
          end
          state_d = (n_d == '0) ? ST_DONE : ST_RDI;
        end
      end
      ST_RDI: begin
        state_d = ST_LDI;
      end
      ST_LDI: begin
        xi_d    = rd_x;
        yi_d    = rd_y;
        j_d     = '0;
        basis_d = QOne;
        state_d = ST_RDJ;
      end
      ST_RDJ: begin
        if (j_q == n_q) begin
          state_d = ST_TERM;
        end else if (j_q == i_q) begin
          j_d = j_q + CW'(1);
        end else begin
          state_d = ST_LDJ;
        end
      end
      ST_LDJ: begin
        if (rd_x == xi_q) begin
          dup_d   = 1'b1;
          state_d = ST_DONE;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          sat_d     = sat_q | div_res.sat;
          mul_start = 1'b1;
          term_d    = 1'b0;
          state_d   = ST_MUL;
        end
      end
      ST_TERM: begin
        mul_start = 1'b1;
        term_d    = 1'b1;
        state_d   = ST_MUL;
      end
      ST_MUL: begin
        if (mul_res.done) begin
          sat_d = sat_q | mul_res.sat;
          if (term_q) begin
            // running sum clamped to the wide range
            if (sum_ext[WideW] != sum_ext[WideW-1]) begin
              sat_d = 1'b1;
              sum_d = sum_ext[WideW] ? WideMin : WideMax;
            end else begin
              sum_d = $signed(sum_ext[WideW-1:0]);
            end
            i_d     = i_q + CW'(1);
            state_d = (i_d == n_q) ? ST_DONE : ST_RDI;
          end else begin
            basis_d = mul_res.res;
            j_d     = j_q + CW'(1);
            state_d = ST_RDJ;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
          if (dup_q) begin
            value_d  = '0;
            status_d = StatusDup;
          end else if (!(&sum_q[WideW-1:31]) && (|sum_q[WideW-1:31])) begin
            value_d  = sum_q[WideW-1] ? 32'h8000_0000 : 32'h7fff_ffff;
            status_d = StatusSat;
          end else begin
            value_d  = sum_q[31:0];
            status_d = sat_q ? StatusSat : StatusOk;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      node_count_q <= NodeCountRst;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        node_count_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    i_q     <= i_d;
    j_q     <= j_d;
    x_q     <= x_d;
    xi_q    <= xi_d;
    yi_q    <= yi_d;
    basis_q <= basis_d;
    sum_q   <= sum_d;
    sat_q   <= sat_d;
    dup_q   <= dup_d;
    term_q  <= term_d;
    if (out_load) begin
      value_q  <= value_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign status_o    = status_q;

endmodule

`default_nettype wire

>>> rtl/lie_chk.sv
`default_nettype none

`include "lagrange_interpolation_evaluator_core_assert.svh"

module lie_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        operation_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [31:0] value_o,
  input wire logic [1:0]  status_o
);

  import lie_pkg::*;

  // a stalled result item holds
  `LIE_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(value_o) && $stable(status_o), "result changed while stalled")

  // a duplicate abscissa reports a zero value
  `LIE_ASSERT_NEVER(a_dup_zero, out_valid_o && status_o == StatusDup && value_o != 32'h0, "duplicate status with nonzero value")

  // a node write into an empty output never makes a result
  `LIE_ASSERT(a_write_silent, in_valid_i && !in_stall_o && operation_i == OpWrite && !out_valid_o |=> !out_valid_o, "node write produced a result")

  // an accepted evaluate keeps the block busy for the next cycle
  `LIE_ASSERT(a_eval_busy, in_valid_i && !in_stall_o && operation_i == OpEval |=> in_stall_o, "evaluate did not occupy the block")

endmodule

bind lagrange_interpolation_evaluator_core lie_chk u_lie_chk (.*);

`default_nettype wire
